[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file of this project.
// Each macro takes a label, a clock, an active-low reset, an antecedent,
// a consequent and a message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/efd_pkg.sv]
// ----------------------------------------------------------------------------
// efd_pkg
// Types and constants shared by the elevator floor dispatch modules.
// ----------------------------------------------------------------------------
package efd_pkg;

    localparam int ACTION_W = 3;
    localparam int FLOOR_W  = 4;
    localparam int POS_W    = 12;
    localparam int FRAC_W   = 8;
    localparam int TOL_W    = 7;
    // Internal floor numbers reach one past a 4-bit floor (up to 16).
    localparam int FIDX_W   = 5;

    localparam logic [FRAC_W-1:0] HALF_FLOOR  = 8'd128;
    localparam logic [POS_W:0]    NEAR_ROUND  = 13'd128;
    localparam logic [TOL_W-1:0]  TOL_RESET   = 7'd13;
    localparam logic [FIDX_W-1:0] FLOOR_ONE   = 5'd1;
    localparam logic [FIDX_W-1:0] FLOOR_NONE  = 5'd0;

    typedef enum logic [ACTION_W-1:0] {
        ACT_SET_PANEL     = 3'd0,
        ACT_SET_HALL      = 3'd1,
        ACT_IDLE_DISPATCH = 3'd2,
        ACT_MOVE_UP       = 3'd3,
        ACT_MOVE_DOWN     = 3'd4,
        ACT_CLEAR_ALL     = 3'd5
    } t_action;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_SCAN   = 2'd1,
        S_UPDATE = 2'd2,
        S_REPLY  = 2'd3
    } t_state;

    typedef struct packed {
        logic load;
        logic scan;
        logic update;
    } t_dp_cmd;

endpackage

[hw/rtl/efd_ctrl.sv]
// ----------------------------------------------------------------------------
// efd_ctrl
// Sequencer: capture, scan, update, reply; one item at a time.
// ----------------------------------------------------------------------------
module efd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    output logic             o_done,
    output efd_pkg::t_dp_cmd o_cmd
);
    import efd_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd.load   = 1'b0;
        o_cmd.scan   = 1'b0;
        o_cmd.update = 1'b0;
        o_done       = 1'b0;
        busy         = 1'b1;
        case (r_state)
            S_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                n_state    = S_UPDATE;
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_REPLY;
            end
            S_REPLY: begin
                o_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/efd_datapath.sv]
// ----------------------------------------------------------------------------
// efd_datapath
// Request masks, direction, target floor and the floor priority scans.
// ----------------------------------------------------------------------------
module efd_datapath #(
    parameter int FLOOR_COUNT = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  efd_pkg::t_dp_cmd             i_cmd,
    input  logic [efd_pkg::ACTION_W-1:0] i_action,
    input  logic [efd_pkg::FLOOR_W-1:0]  i_floor,
    input  logic                         i_up_button,
    input  logic                         i_lit,
    input  logic [efd_pkg::POS_W-1:0]    i_car_floor_pos,
    input  logic                         i_cfg_we,
    input  logic [efd_pkg::TOL_W-1:0]    i_cfg_wdata,
    output logic [efd_pkg::FLOOR_W-1:0]  o_target_floor,
    output logic                         o_going_up
);
    import efd_pkg::*;

    // Captured item.
    t_action            r_action;
    logic [FLOOR_W-1:0] r_floor;
    logic               r_up_button;
    logic               r_lit;
    logic [POS_W-1:0]   r_pos;

    // Architectural state.
    logic [TOL_W-1:0]       r_tol;
    logic [FLOOR_COUNT-1:0] r_panel, n_panel;
    logic [FLOOR_COUNT-1:0] r_hall_up, n_hall_up;
    logic [FLOOR_COUNT-1:0] r_hall_dn, n_hall_dn;
    logic                   r_dir_up, n_dir_up;
    logic [FIDX_W-1:0]      r_stop, n_stop;

    // Scan results.
    logic [FIDX_W-1:0] r_up_a, n_up_a, r_up_b, n_up_b;
    logic [FIDX_W-1:0] r_dn_a, n_dn_a, r_dn_b, n_dn_b;
    logic r_nu_p, n_nu_p, r_nu_hd, n_nu_hd;
    logic r_np_pd, n_np_pd, r_np_hu, n_np_hu;

    // Position views.
    logic [POS_W:0]         w_round;
    logic [FIDX_W-1:0]      w_near;
    logic [FIDX_W-1:0]      w_passed;
    logic [FIDX_W-1:0]      w_next;
    logic [FRAC_W-1:0]      w_frac;
    logic                   w_level;
    logic [FLOOR_COUNT-1:0] w_pu;
    logic [FLOOR_COUNT-1:0] w_pd;
    logic [FIDX_W-1:0]      w_su;
    logic [FIDX_W-1:0]      w_sd;
    logic                   w_dir0;

    assign w_round  = {1'b0, r_pos} + NEAR_ROUND;
    assign w_near   = w_round[POS_W:FRAC_W];
    assign w_passed = {1'b0, r_pos[POS_W-1:FRAC_W]};
    assign w_next   = w_passed + FLOOR_ONE;
    assign w_frac   = r_pos[FRAC_W-1:0];
    assign w_level  = w_frac < {1'b0, r_tol};
    assign w_pu     = r_panel | r_hall_up;
    assign w_pd     = r_panel | r_hall_dn;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action    <= t_action'(i_action);
            r_floor     <= i_floor;
            r_up_button <= i_up_button;
            r_lit       <= i_lit;
            r_pos       <= i_car_floor_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
        end else if (i_cfg_we) begin
            r_tol <= i_cfg_wdata;
        end
    end

    // Scan stage: nearest requests above and below the nearest floor, and the
    // request bits at the floor just passed and the one above it.
    always_comb begin
        n_up_a  = FLOOR_NONE;
        n_up_b  = FLOOR_NONE;
        n_dn_a  = FLOOR_NONE;
        n_dn_b  = FLOOR_NONE;
        n_nu_p  = 1'b0;
        n_nu_hd = 1'b0;
        n_np_pd = 1'b0;
        n_np_hu = 1'b0;
        for (int i = FLOOR_COUNT - 1; i >= 0; i--) begin
            if (FIDX_W'(i + 1) > w_near) begin
                if (w_pu[i]) begin
                    n_up_a = FIDX_W'(i + 1);
                end
                if (r_hall_dn[i]) begin
                    n_up_b = FIDX_W'(i + 1);
                end
            end
        end
        for (int i = 0; i < FLOOR_COUNT; i++) begin
            if (FIDX_W'(i + 1) < w_near) begin
                if (w_pd[i]) begin
                    n_dn_a = FIDX_W'(i + 1);
                end
                if (r_hall_up[i]) begin
                    n_dn_b = FIDX_W'(i + 1);
                end
            end
            if (FIDX_W'(i + 1) == w_next) begin
                n_nu_p  = w_pu[i];
                n_nu_hd = r_hall_dn[i];
            end
            if (FIDX_W'(i + 1) == w_passed) begin
                n_np_pd = w_pd[i];
                n_np_hu = r_hall_up[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan) begin
            r_up_a  <= n_up_a;
            r_up_b  <= n_up_b;
            r_dn_a  <= n_dn_a;
            r_dn_b  <= n_dn_b;
            r_nu_p  <= n_nu_p;
            r_nu_hd <= n_nu_hd;
            r_np_pd <= n_np_pd;
            r_np_hu <= n_np_hu;
        end
    end

    assign w_su = (r_up_a != FLOOR_NONE) ? r_up_a : r_up_b;
    assign w_sd = (r_dn_a != FLOOR_NONE) ? r_dn_a : r_dn_b;
    assign w_dir0 = (w_near == FLOOR_ONE) ? 1'b1 :
                    (w_near == FIDX_W'(FLOOR_COUNT)) ? 1'b0 : r_dir_up;

    // Update stage.
    always_comb begin
        n_panel   = r_panel;
        n_hall_up = r_hall_up;
        n_hall_dn = r_hall_dn;
        n_dir_up  = r_dir_up;
        n_stop    = r_stop;
        case (r_action)
            ACT_SET_PANEL: begin
                for (int i = 0; i < FLOOR_COUNT; i++) begin
                    if (FIDX_W'(i + 1) == {1'b0, r_floor}) begin
                        n_panel[i] = r_lit;
                    end
                end
            end
            ACT_SET_HALL: begin
                for (int i = 0; i < FLOOR_COUNT; i++) begin
                    if (FIDX_W'(i + 1) == {1'b0, r_floor}) begin
                        if (r_up_button) begin
                            n_hall_up[i] = r_lit;
                        end else begin
                            n_hall_dn[i] = r_lit;
                        end
                    end
                end
            end
            ACT_IDLE_DISPATCH: begin
                // An empty search in the current direction reverses it.
                if (w_dir0) begin
                    if (w_su != FLOOR_NONE) begin
                        n_stop   = w_su;
                        n_dir_up = 1'b1;
                    end else begin
                        n_stop   = w_sd;
                        n_dir_up = 1'b0;
                    end
                end else begin
                    if (w_sd != FLOOR_NONE) begin
                        n_stop   = w_sd;
                        n_dir_up = 1'b0;
                    end else begin
                        n_stop   = w_su;
                        n_dir_up = 1'b1;
                    end
                end
            end
            ACT_MOVE_UP: begin
                if (!((w_level && r_stop == w_passed) || r_stop == w_next ||
                      w_frac > HALF_FLOOR)) begin
                    if (r_nu_p) begin
                        n_stop = w_next;
                    end else if (r_stop < w_next && r_nu_hd) begin
                        n_stop = w_next;
                    end
                end
            end
            ACT_MOVE_DOWN: begin
                if (w_level && w_passed == FLOOR_ONE) begin
                    n_stop = FLOOR_ONE;
                end else if (!(r_stop == w_passed || w_frac < HALF_FLOOR)) begin
                    if (r_np_pd) begin
                        n_stop = w_passed;
                    end else if (r_stop >= w_passed && r_np_hu) begin
                        n_stop = w_passed;
                    end
                end
            end
            ACT_CLEAR_ALL: begin
                n_panel   = '0;
                n_hall_up = '0;
                n_hall_dn = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_panel   <= '0;
            r_hall_up <= '0;
            r_hall_dn <= '0;
            r_dir_up  <= 1'b1;
            r_stop    <= FLOOR_NONE;
        end else if (i_cmd.update) begin
            r_panel   <= n_panel;
            r_hall_up <= n_hall_up;
            r_hall_dn <= n_hall_dn;
            r_dir_up  <= n_dir_up;
            r_stop    <= n_stop;
        end
    end

    assign o_target_floor = r_stop[FLOOR_W-1:0];
    assign o_going_up     = r_dir_up;

endmodule

[hw/rtl/elevator_floor_dispatch_top.sv]
// ----------------------------------------------------------------------------
// elevator_floor_dispatch_top
// Collective-control dispatch: request lights, direction and target floor.
// ----------------------------------------------------------------------------
// Usage:
//   An item (action, floor, up button, lit, car position) is taken at a
//   rising edge where start is high and busy is low. busy then stays high
//   while the item goes through the sequencer states in order: a scan state that
//   runs the floor priority encoders over the request masks, an update state
//   that writes masks, direction and target, and a reply state in which o_done
//   is high for one cycle with o_target_floor and o_going_up.
//   Every item, unused action codes too, gives exactly one result.
//   A new item is taken only after the previous one has given its result
//   and busy is low again.
//   The result is shown for one cycle only; the receiver cannot stall it.
//   The tolerance register is written through i_cfg_we and i_cfg_wdata and
//   is meant to change only while busy is low.
//   Synchronous reset clears all request lights, sets the direction to up,
//   the target to none and the tolerance to 13/256 of a floor.
// ----------------------------------------------------------------------------
module elevator_floor_dispatch_top #(
    parameter int FLOOR_COUNT = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [efd_pkg::ACTION_W-1:0] i_action,
    input  logic [efd_pkg::FLOOR_W-1:0]  i_floor,
    input  logic                         i_up_button,
    input  logic                         i_lit,
    input  logic [efd_pkg::POS_W-1:0]    i_car_floor_pos,
    input  logic                         i_cfg_we,
    input  logic [efd_pkg::TOL_W-1:0]    i_cfg_wdata,
    output logic                         o_done,
    output logic [efd_pkg::FLOOR_W-1:0]  o_target_floor,
    output logic                         o_going_up
);
    import efd_pkg::*;

    t_dp_cmd w_cmd;

    efd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_done  (o_done),
        .o_cmd   (w_cmd)
    );

    efd_datapath #(
        .FLOOR_COUNT (FLOOR_COUNT)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_action        (i_action),
        .i_floor         (i_floor),
        .i_up_button     (i_up_button),
        .i_lit           (i_lit),
        .i_car_floor_pos (i_car_floor_pos),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_target_floor  (o_target_floor),
        .o_going_up      (o_going_up)
    );

endmodule

[hw/rtl/efd_checker.sv]
// ----------------------------------------------------------------------------
// efd_checker
// Port-level checks of the dispatch block's item sequencing.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module efd_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        o_done,
    input logic [efd_pkg::FLOOR_W-1:0] o_target_floor,
    input logic                        o_going_up
);
    import efd_pkg::*;

    // An accepted item puts the block into its busy state before any result is shown.
    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy && !o_done, "item accepted but block not busy")

    // The result strobe only appears while an item is in flight.
    `ASSERT_SAME(a_done_busy, i_clk, i_rst_n, o_done, busy, "result shown while idle")

    // After the result the block is ready for the next item.
    `ASSERT_NEXT(a_done_idle, i_clk, i_rst_n, o_done, !busy && !o_done, "block not ready after result")

    // Target and direction only move while an item is being worked on.
    `ASSERT_NEXT(a_idle_stable, i_clk, i_rst_n, !busy, $stable(o_target_floor) && $stable(o_going_up), "state changed while idle")

endmodule

bind elevator_floor_dispatch_top efd_checker u_efd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_done         (o_done),
    .o_target_floor (o_target_floor),
    .o_going_up     (o_going_up)
);
